@@ rtl/tpbe_pkg.sv @@
// Shared types, codes and reset values of the tape pulse block encoder.
package tpbe_pkg;

	// Default bytes per buffer bank
	localparam int BUF_DEPTH_DEF = 256;

	// Top bit of a byte, first bit sent
	localparam logic [7:0] BIT_MASK_TOP = 8'h80;

	// Register reset values
	localparam logic [15:0] PILOT_PULSE_LEN_RST    = 16'd2168;
	localparam logic [15:0] SYNC_FIRST_LEN_RST     = 16'd667;
	localparam logic [15:0] SYNC_SECOND_LEN_RST    = 16'd735;
	localparam logic [15:0] FINAL_PULSE_LEN_RST    = 16'd945;
	localparam logic [15:0] ONE_BIT_LEN_RST        = 16'd1710;
	localparam logic [15:0] ZERO_BIT_LEN_RST       = 16'd855;
	localparam logic [15:0] HEADER_PILOT_COUNT_RST = 16'd8063;
	localparam logic [15:0] DATA_PILOT_COUNT_RST   = 16'd3223;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_PILOT_PULSE_LEN    = 3'd0,
		REG_SYNC_FIRST_LEN     = 3'd1,
		REG_SYNC_SECOND_LEN    = 3'd2,
		REG_FINAL_PULSE_LEN    = 3'd3,
		REG_ONE_BIT_LEN        = 3'd4,
		REG_ZERO_BIT_LEN       = 3'd5,
		REG_HEADER_PILOT_COUNT = 3'd6,
		REG_DATA_PILOT_COUNT   = 3'd7
	} reg_idx_t;

	// Request commands
	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_START = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	// Block stages, one-hot
	typedef enum logic [6:0] {
		ST_PILOT  = 7'b0000001,
		ST_SYNC1  = 7'b0000010,
		ST_SYNC2  = 7'b0000100,
		ST_DATA   = 7'b0001000,
		ST_FINAL1 = 7'b0010000,
		ST_FINAL2 = 7'b0100000,
		ST_FINISH = 7'b1000000
	} stage_t;

	// Timing configuration handed to the core
	typedef struct packed {
		logic [15:0] pilot_pulse_len;
		logic [15:0] sync_first_len;
		logic [15:0] sync_second_len;
		logic [15:0] final_pulse_len;
		logic [15:0] one_bit_len;
		logic [15:0] zero_bit_len;
		logic [15:0] header_pilot_count;
		logic [15:0] data_pilot_count;
	} cfg_t;

endpackage

@@ rtl/tpbe_ram.sv @@
// Generic simple RAM: one write port, two registered read ports.
module tpbe_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 512,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr_a,
	input  logic [ADDR_W-1:0] raddr_b,
	output logic [WIDTH-1:0]  rdata_a,
	output logic [WIDTH-1:0]  rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and read, read data returns old contents on a collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

@@ rtl/tpbe_cfg.sv @@
// Configuration register file of the tape pulse block encoder.
module tpbe_cfg
	import tpbe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [2:0] wr_index,
	input  logic [15:0] wr_data,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	assign cfg = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pilot_pulse_len    <= PILOT_PULSE_LEN_RST;
			cfg_q.sync_first_len     <= SYNC_FIRST_LEN_RST;
			cfg_q.sync_second_len    <= SYNC_SECOND_LEN_RST;
			cfg_q.final_pulse_len    <= FINAL_PULSE_LEN_RST;
			cfg_q.one_bit_len        <= ONE_BIT_LEN_RST;
			cfg_q.zero_bit_len       <= ZERO_BIT_LEN_RST;
			cfg_q.header_pilot_count <= HEADER_PILOT_COUNT_RST;
			cfg_q.data_pilot_count   <= DATA_PILOT_COUNT_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_PILOT_PULSE_LEN:    cfg_q.pilot_pulse_len    <= wr_data;
				REG_SYNC_FIRST_LEN:     cfg_q.sync_first_len     <= wr_data;
				REG_SYNC_SECOND_LEN:    cfg_q.sync_second_len    <= wr_data;
				REG_FINAL_PULSE_LEN:    cfg_q.final_pulse_len    <= wr_data;
				REG_ONE_BIT_LEN:        cfg_q.one_bit_len        <= wr_data;
				REG_ZERO_BIT_LEN:       cfg_q.zero_bit_len       <= wr_data;
				REG_HEADER_PILOT_COUNT: cfg_q.header_pilot_count <= wr_data;
				REG_DATA_PILOT_COUNT:   cfg_q.data_pilot_count   <= wr_data;
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/tpbe_core.sv @@
// Stage sequencer, buffer bookkeeping and output register of the encoder.
module tpbe_core
	import tpbe_pkg::*;
#(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF,
	parameter int ADDR_W    = (2 * BUF_DEPTH > 1) ? $clog2(2 * BUF_DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	// request channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        command,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic              block_type,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic              level,
	output logic [15:0]       period_states,
	output logic              finished,
	output logic              buffer_empty,
	// byte store
	output logic              ram_we,
	output logic [ADDR_W-1:0] ram_waddr,
	output logic [7:0]        ram_wdata,
	output logic [ADDR_W-1:0] ram_raddr_a,
	output logic [ADDR_W-1:0] ram_raddr_b,
	input  logic [7:0]        ram_rdata_a,
	input  logic [7:0]        ram_rdata_b
);

	// Count width holds the depth itself
	localparam int CW = $clog2(BUF_DEPTH + 1);

	// Store address of an entry of a bank
	function automatic logic [ADDR_W-1:0] store_addr(input logic bank,
	                                                input logic [CW-1:0] idx);
		logic [ADDR_W-1:0] base;
		base = bank ? ADDR_W'(BUF_DEPTH) : '0;
		return base + ADDR_W'(idx);
	endfunction

	// State registers
	logic          fill_bank_q, fill_bank_n;
	logic [CW-1:0] fill_count_q, fill_count_n;
	logic [CW-1:0] fill_length_q, fill_length_n;
	logic [CW-1:0] send_length_q, send_length_n;
	logic [CW-1:0] send_index_q, send_index_n;
	logic [7:0]    bit_mask_q, bit_mask_n;
	logic [7:0]    shift_byte_q, shift_byte_n;
	stage_t        stage_q, stage_n;
	logic [15:0]   pulse_counter_q, pulse_counter_n;
	logic          half_wave_up_q, half_wave_up_n;
	logic          bit_value_q, bit_value_n;
	logic [15:0]   half_period_q, half_period_n;

	// Forwarding of a load into the swap-side read
	logic          fwd_hit_q;
	logic [7:0]    fwd_data_q;
	logic [7:0]    swap_byte;

	// Output register
	logic          out_valid_q;
	logic          level_q;
	logic [15:0]   period_q;
	logic          finished_q;
	logic          empty_q;

	// Data-stage work values
	logic          accept;
	logic          lvl;
	logic          swap_go;
	logic          bit_v;
	logic [CW-1:0] slen_v;
	logic [CW-1:0] sidx_v;
	logic [7:0]    mask_v;
	logic [7:0]    shift_v;

	assign in_stall  = out_valid_q & out_stall;
	assign accept    = in_valid & ~in_stall;
	assign swap_byte = fwd_hit_q ? fwd_data_q : ram_rdata_b;

	// Next state for the accepted request
	always_comb begin
		fill_bank_n     = fill_bank_q;
		fill_count_n    = fill_count_q;
		fill_length_n   = fill_length_q;
		send_length_n   = send_length_q;
		send_index_n    = send_index_q;
		bit_mask_n      = bit_mask_q;
		shift_byte_n    = shift_byte_q;
		stage_n         = stage_q;
		pulse_counter_n = pulse_counter_q;
		half_wave_up_n  = half_wave_up_q;
		bit_value_n     = bit_value_q;
		half_period_n   = half_period_q;
		lvl             = 1'b0;
		swap_go         = 1'b0;
		bit_v           = 1'b0;
		slen_v          = send_length_q;
		sidx_v          = send_index_q;
		mask_v          = bit_mask_q;
		shift_v         = shift_byte_q;
		ram_we          = 1'b0;
		ram_waddr       = store_addr(fill_bank_q, fill_count_q);
		ram_wdata       = data_byte;

		if (accept) begin
			case (cmd_t'(command))
				CMD_TICK: begin
					case (stage_q)
						ST_PILOT: begin
							half_period_n = cfg.pilot_pulse_len;
							if (!half_wave_up_q) begin
								pulse_counter_n = pulse_counter_q - 16'd1;
								if (pulse_counter_n == '0) begin
									stage_n = ST_SYNC1;
								end
							end
							lvl            = half_wave_up_q;
							half_wave_up_n = ~half_wave_up_q;
						end
						ST_SYNC1: begin
							half_period_n = cfg.sync_first_len;
							stage_n       = ST_SYNC2;
							lvl           = 1'b1;
						end
						ST_SYNC2: begin
							half_period_n = cfg.sync_second_len;
							stage_n       = ST_DATA;
						end
						ST_DATA: begin
							if (half_wave_up_q && send_length_q == '0 && bit_mask_q == '0
									&& fill_length_q == '0) begin
								// nothing left to send: final pulse
								half_period_n = cfg.final_pulse_len;
								stage_n       = ST_FINAL1;
								lvl           = 1'b1;
							end else begin
								if (half_wave_up_q) begin
									// swap banks when the send side is dry
									if (send_length_q == '0 && bit_mask_q == '0) begin
										swap_go       = 1'b1;
										fill_bank_n   = ~fill_bank_q;
										slen_v        = fill_length_q;
										sidx_v        = '0;
										fill_length_n = '0;
										fill_count_n  = '0;
									end
									// fetch the next byte
									if (mask_v == '0) begin
										mask_v  = BIT_MASK_TOP;
										shift_v = swap_go ? swap_byte : ram_rdata_a;
										sidx_v  = sidx_v + CW'(1);
										if (sidx_v == slen_v) begin
											slen_v = '0;
										end
									end
									bit_v         = |(shift_v & mask_v);
									bit_mask_n    = mask_v >> 1;
									shift_byte_n  = shift_v;
									send_length_n = slen_v;
									send_index_n  = sidx_v;
									bit_value_n   = bit_v;
								end
								half_period_n  = bit_value_n ? cfg.one_bit_len : cfg.zero_bit_len;
								lvl            = half_wave_up_q;
								half_wave_up_n = ~half_wave_up_q;
							end
						end
						ST_FINAL1: stage_n = ST_FINAL2;
						ST_FINAL2: stage_n = ST_FINISH;
						ST_FINISH: begin
							fill_length_n = '0;
							send_length_n = '0;
							send_index_n  = '0;
							bit_mask_n    = '0;
							half_period_n = '0;
						end
						default: ;
					endcase
				end
				CMD_LOAD: begin
					if (fill_count_q < CW'(BUF_DEPTH)) begin
						ram_we       = 1'b1;
						fill_count_n = fill_count_q + CW'(1);
					end
					if (last_byte) begin
						fill_length_n = fill_count_n;
						fill_count_n  = '0;
					end
				end
				CMD_START: begin
					stage_n         = ST_PILOT;
					pulse_counter_n = block_type ? cfg.data_pilot_count
					                             : cfg.header_pilot_count;
				end
				default: ;
			endcase
		end
	end

	// Read addresses follow the next state so data is ready for the next request
	assign ram_raddr_a = store_addr(~fill_bank_n, send_index_n);
	assign ram_raddr_b = store_addr(fill_bank_n, '0);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_bank_q     <= 1'b0;
			fill_count_q    <= '0;
			fill_length_q   <= '0;
			send_length_q   <= '0;
			send_index_q    <= '0;
			bit_mask_q      <= '0;
			shift_byte_q    <= '0;
			stage_q         <= ST_FINISH;
			pulse_counter_q <= '0;
			half_wave_up_q  <= 1'b0;
			bit_value_q     <= 1'b0;
			half_period_q   <= '0;
			fwd_hit_q       <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			fill_bank_q     <= fill_bank_n;
			fill_count_q    <= fill_count_n;
			fill_length_q   <= fill_length_n;
			send_length_q   <= send_length_n;
			send_index_q    <= send_index_n;
			bit_mask_q      <= bit_mask_n;
			shift_byte_q    <= shift_byte_n;
			stage_q         <= stage_n;
			pulse_counter_q <= pulse_counter_n;
			half_wave_up_q  <= half_wave_up_n;
			bit_value_q     <= bit_value_n;
			half_period_q   <= half_period_n;
			fwd_hit_q       <= ram_we && (ram_waddr == ram_raddr_b);
			out_valid_q     <= accept | (out_valid_q & out_stall);
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		fwd_data_q <= ram_wdata;
		if (accept) begin
			level_q    <= lvl;
			period_q   <= half_period_n;
			finished_q <= (stage_n == ST_FINISH);
			empty_q    <= (fill_length_n == '0);
		end
	end

	assign out_valid     = out_valid_q;
	assign level         = level_q;
	assign period_states = period_q;
	assign finished      = finished_q;
	assign buffer_empty  = empty_q;

endmodule

@@ rtl/tape_pulse_block_encoder_top.sv @@
// A result is registered and valid in the cycle after its request is accepted.
// Throughput: one request per cycle; a new request is taken in the cycle the last
// result leaves, the output register stalls input only while its result is held.
// The byte store is a two-bank RAM with registered reads, addressed ahead.
// Reset: asynchronous, clears all control state and loads register defaults.
// The byte store is not cleared; there is no clearing pass.
module tape_pulse_block_encoder_top
	import tpbe_pkg::*;
#(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// requests
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        block_type,
	// results
	output logic        out_valid,
	input  logic        out_stall,
	output logic        level,
	output logic [15:0] period_states,
	output logic        finished,
	output logic        buffer_empty
);

	localparam int STORE_DEPTH = 2 * BUF_DEPTH;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	cfg_t              cfg;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic [ADDR_W-1:0] ram_raddr_a;
	logic [ADDR_W-1:0] ram_raddr_b;
	logic [7:0]        ram_rdata_a;
	logic [7:0]        ram_rdata_b;

	assign cfg_ready = 1'b1;

	// Timing registers
	tpbe_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Ping-pong byte store
	tpbe_ram #(
		.WIDTH  (8),
		.DEPTH  (STORE_DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

	// Sequencer
	tpbe_core #(
		.BUF_DEPTH (BUF_DEPTH),
		.ADDR_W    (ADDR_W)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.block_type    (block_type),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.level         (level),
		.period_states (period_states),
		.finished      (finished),
		.buffer_empty  (buffer_empty),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_raddr_a   (ram_raddr_a),
		.ram_raddr_b   (ram_raddr_b),
		.ram_rdata_a   (ram_rdata_a),
		.ram_rdata_b   (ram_rdata_b)
	);

endmodule
